// ----- design/sob_pkg.sv -----
// Shared constants, codes and controller/datapath types for the Sobol generator.
`timescale 1ns / 1ps
package sob_pkg;

   localparam int DEF_MAX_DIMS   = 64;
   localparam int DEF_MAX_DEGREE = 16;
   localparam int FRACTION_BITS  = 32;

   localparam int OP_W     = 2;
   localparam int DIM_W    = 6;
   localparam int DEGREE_W = 5;
   localparam int COEFF_W  = 15;
   localparam int MIDX_W   = 5;
   localparam int MVAL_W   = 16;
   localparam int STATUS_W = 2;
   localparam int NDIMS_W  = 7;
   localparam int STEP_W   = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_LOAD_POLY = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_M    = 2'd1;
   localparam logic [OP_W-1:0] OP_GENERATE  = 2'd2;
   localparam logic [OP_W-1:0] OP_RESTART   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_CFG   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_POINTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_DIMS   = 1'd1;

   typedef struct packed {
      logic                ld_poly;
      logic                ld_m;
      logic                restart;
      logic                cnt_inc;
      logic                clr_lp;
      logic                rd_dim;
      logic                step;
      logic                emit;
      logic                emit_err;
      logic [STATUS_W-1:0] err_code;
      logic [NDIMS_W-1:0]  dim;
      logic [STEP_W-1:0]   step_idx;
      logic [STEP_W-1:0]   c;
      logic                first_pt;
   } cmd_type;

   typedef struct packed {
      logic                     cfg_bad;
      logic                     exhausted;
      logic [FRACTION_BITS-1:0] point_count;
      logic [NDIMS_W-1:0]       dcount;
      logic                     out_free;
   } status_type;

endpackage

// ----- design/sob_if.sv -----
// Channel interfaces: request, response and register write.
`timescale 1ns / 1ps
interface sob_req_if;
   logic                             valid;
   logic                             ready;
   logic [sob_pkg::OP_W-1:0]         operation;
   logic [sob_pkg::DIM_W-1:0]        dim_index;
   logic [sob_pkg::DEGREE_W-1:0]     poly_degree;
   logic [sob_pkg::COEFF_W-1:0]      poly_coeffs;
   logic [sob_pkg::MIDX_W-1:0]       m_index;
   logic [sob_pkg::MVAL_W-1:0]       m_value;
   modport source (output valid, operation, dim_index, poly_degree, poly_coeffs,
                   m_index, m_value, input ready);
   modport sink (input valid, operation, dim_index, poly_degree, poly_coeffs,
                 m_index, m_value, output ready);
endinterface

interface sob_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sob_pkg::FRACTION_BITS-1:0]  coordinate;
   logic [sob_pkg::DIM_W-1:0]          dim_out;
   logic                               last_of_point;
   logic [sob_pkg::STATUS_W-1:0]       status;
   modport source (output valid, coordinate, dim_out, last_of_point, status,
                   input ready);
   modport sink (input valid, coordinate, dim_out, last_of_point, status,
                 output ready);
endinterface

interface sob_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sob_pkg::CSR_IDX_W-1:0]     index;
   logic [sob_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/sob_ctrl.sv -----
// Sequencer: decodes requests, walks dimensions and recurrence steps.
`timescale 1ns / 1ps
module sob_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [sob_pkg::OP_W-1:0]    req_op,
   output logic                        req_ready,
   input  sob_pkg::status_type         sts,
   output sob_pkg::cmd_type            cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CTZ  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_STEP = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_ERR  = 3'd5;

   localparam logic [sob_pkg::STEP_W-1:0] C_MAX =
      sob_pkg::STEP_W'(sob_pkg::FRACTION_BITS);

   logic [2:0]                         state_ff, state_in;
   logic [sob_pkg::NDIMS_W-1:0]        dim_ff, dim_in;
   logic [sob_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [sob_pkg::STEP_W-1:0]         c_ff, c_in;
   logic                               first_ff, first_in;
   logic [sob_pkg::FRACTION_BITS-1:0]  tz_ff, tz_in;
   logic [sob_pkg::STATUS_W-1:0]       err_ff, err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dim_ff   <= dim_in;
      step_ff  <= step_in;
      c_ff     <= c_in;
      first_ff <= first_in;
      tz_ff    <= tz_in;
      err_ff   <= err_in;
   end

   always_comb begin
      state_in = state_ff;
      dim_in   = dim_ff;
      step_in  = step_ff;
      c_in     = c_ff;
      first_in = first_ff;
      tz_in    = tz_ff;
      err_in   = err_ff;
      cmd          = '0;
      cmd.dim      = dim_ff;
      cmd.step_idx = step_ff;
      cmd.c        = c_ff;
      cmd.first_pt = first_ff;
      cmd.err_code = err_ff;
      req_ready    = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  sob_pkg::OP_LOAD_POLY: cmd.ld_poly = 1'b1;
                  sob_pkg::OP_LOAD_M:    cmd.ld_m = 1'b1;
                  sob_pkg::OP_RESTART:   cmd.restart = 1'b1;
                  sob_pkg::OP_GENERATE: begin
                     priority if (sts.cfg_bad) begin
                        err_in   = sob_pkg::ST_NOT_CFG;
                        state_in = S_ERR;
                     end else if (sts.exhausted) begin
                        err_in   = sob_pkg::ST_EXHAUSTED;
                        state_in = S_ERR;
                     end else begin
                        cmd.cnt_inc = 1'b1;
                        dim_in      = '0;
                        if (sts.point_count == '0) begin
                           first_in   = 1'b1;
                           cmd.clr_lp = 1'b1;
                           state_in   = S_RD;
                        end else begin
                           first_in = 1'b0;
                           tz_in    = sts.point_count - 1'b1;
                           c_in     = sob_pkg::STEP_W'(1);
                           state_in = S_CTZ;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_CTZ: begin
            // C = 1 + trailing ones of k-1, capped at the fraction width
            if (tz_ff[0] && (c_ff < C_MAX)) begin
               tz_in = tz_ff >> 1;
               c_in  = c_ff + 1'b1;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd_dim = 1'b1;
            step_in    = sob_pkg::STEP_W'(1);
            state_in   = (first_ff || (dim_ff == '0)) ? S_EMIT : S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (step_ff == c_ff) begin
               state_in = S_EMIT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if ((dim_ff + 1'b1) == sts.dcount) begin
                  state_in = S_IDLE;
               end else begin
                  dim_in   = dim_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- design/sob_dpath.sv -----
// Datapath: registers, tables, direction-number recurrence and output word.
`timescale 1ns / 1ps
module sob_dpath #(
   parameter int MAX_DIMS   = sob_pkg::DEF_MAX_DIMS,
   parameter int MAX_DEGREE = sob_pkg::DEF_MAX_DEGREE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sob_pkg::cmd_type                      cmd,
   output sob_pkg::status_type                   sts,
   input  logic [sob_pkg::DIM_W-1:0]             req_dim_index,
   input  logic [sob_pkg::DEGREE_W-1:0]          req_poly_degree,
   input  logic [sob_pkg::COEFF_W-1:0]           req_poly_coeffs,
   input  logic [sob_pkg::MIDX_W-1:0]            req_m_index,
   input  logic [sob_pkg::MVAL_W-1:0]            req_m_value,
   input  logic                                  csr_valid,
   input  logic [sob_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sob_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                  csr_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sob_pkg::FRACTION_BITS-1:0]     rsp_coordinate,
   output logic [sob_pkg::DIM_W-1:0]             rsp_dim_out,
   output logic                                  rsp_last_of_point,
   output logic [sob_pkg::STATUS_W-1:0]          rsp_status
);

   localparam int FB     = sob_pkg::FRACTION_BITS;
   localparam int LP_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DEG_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
   localparam int M_DEPTH = MAX_DIMS * MAX_DEGREE;
   localparam int MA_W   = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;

   // configuration and point counter
   logic [FB-1:0]                      num_points_ff;
   logic [sob_pkg::NDIMS_W-1:0]        num_dims_ff;
   logic [FB-1:0]                      pc_ff;
   logic [sob_pkg::NDIMS_W-1:0]        dcount;

   // tables
   logic [sob_pkg::DEGREE_W-1:0]       deg_mem [MAX_DIMS];
   logic [sob_pkg::COEFF_W-1:0]        coeff_mem [MAX_DIMS];
   logic [sob_pkg::MVAL_W-1:0]         m_mem [M_DEPTH];
   logic [FB-1:0]                      lp_mem [MAX_DIMS];
   logic [MAX_DIMS-1:0]                lp_vld_ff;

   logic [sob_pkg::DEGREE_W-1:0]       deg_rd_ff;
   logic [sob_pkg::COEFF_W-1:0]        coeff_rd_ff;
   logic [sob_pkg::MVAL_W-1:0]         m_rd_ff;
   logic [FB-1:0]                      lp_rd_ff;
   logic                               lp_vld_rd_ff;

   // recurrence window: w_ff[k] holds v[i-k]
   logic [FB-1:0]                      w_ff [1:MAX_DEGREE];

   logic                               rsp_valid_ff;
   logic [FB-1:0]                      coord_ff;
   logic [sob_pkg::DIM_W-1:0]          dim_out_ff;
   logic                               last_ff;
   logic [sob_pkg::STATUS_W-1:0]       status_ff;

   logic [sob_pkg::DEGREE_W-1:0]       s_eff;
   logic [FB-1:0]                      w_s;
   logic [FB-1:0]                      v_rec;
   logic [FB-1:0]                      v_new;
   logic [sob_pkg::COEFF_W-1:0]        a_sh;
   logic [DEG_W-1:0]                   m_entry;
   logic [MA_W-1:0]                    m_rd_addr;
   logic [MA_W-1:0]                    m_wr_addr;
   logic [LP_AW-1:0]                   dim_addr;
   logic [FB-1:0]                      lp_cur;
   logic [FB-1:0]                      emit_val;
   logic                               emit_last;
   logic                               ld_dim_ok;
   logic                               ld_m_ok;

   assign csr_ready = 1'b1;
   assign dcount = (32'(num_dims_ff) > MAX_DIMS) ? sob_pkg::NDIMS_W'(MAX_DIMS) : num_dims_ff;

   assign sts.cfg_bad     = (num_points_ff == '0) || (dcount == '0);
   assign sts.exhausted   = (pc_ff >= num_points_ff);
   assign sts.point_count = pc_ff;
   assign sts.dcount      = dcount;
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= '0;
         num_dims_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            sob_pkg::REG_NUM_POINTS: num_points_ff <= csr_data;
            sob_pkg::REG_NUM_DIMS:   num_dims_ff <= csr_data[sob_pkg::NDIMS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else if (cmd.restart) begin
         pc_ff <= '0;
      end else if (cmd.cnt_inc) begin
         pc_ff <= pc_ff + 1'b1;
      end
   end

   // table loads
   assign ld_dim_ok = (32'(req_dim_index) < MAX_DIMS);
   assign ld_m_ok   = ld_dim_ok && (req_m_index != '0) && (32'(req_m_index) <= MAX_DEGREE);
   assign m_wr_addr = MA_W'(32'(req_dim_index) * MAX_DEGREE + 32'(req_m_index) - 1);

   always_ff @(posedge clock) begin
      if (cmd.ld_poly && ld_dim_ok) begin
         deg_mem[LP_AW'(req_dim_index)]   <= req_poly_degree;
         coeff_mem[LP_AW'(req_dim_index)] <= req_poly_coeffs;
      end
      if (cmd.ld_m && ld_m_ok) begin
         m_mem[m_wr_addr] <= req_m_value;
      end
   end

   // reads for the current dimension; m is fetched one step ahead
   assign dim_addr = LP_AW'(cmd.dim);
   always_comb begin
      if (cmd.step && (32'(cmd.step_idx) < MAX_DEGREE)) begin
         m_entry = DEG_W'(cmd.step_idx);
      end else begin
         m_entry = '0;
      end
   end
   assign m_rd_addr = MA_W'(32'(dim_addr) * MAX_DEGREE + 32'(m_entry));

   always_ff @(posedge clock) begin
      if (cmd.rd_dim) begin
         deg_rd_ff    <= deg_mem[dim_addr];
         coeff_rd_ff  <= coeff_mem[dim_addr];
         lp_rd_ff     <= lp_mem[dim_addr];
         lp_vld_rd_ff <= lp_vld_ff[dim_addr];
      end
      if (cmd.rd_dim || cmd.step) begin
         m_rd_ff <= m_mem[m_rd_addr];
      end
   end

   // recurrence step
   always_comb begin
      if (deg_rd_ff == '0) begin
         s_eff = sob_pkg::DEGREE_W'(1);
      end else if (32'(deg_rd_ff) > MAX_DEGREE) begin
         s_eff = sob_pkg::DEGREE_W'(MAX_DEGREE);
      end else begin
         s_eff = deg_rd_ff;
      end
   end

   always_comb begin
      w_s = '0;
      for (int k = 1; k <= MAX_DEGREE; k++) begin
         if (32'(s_eff) == k) w_s = w_ff[k];
      end
      v_rec = w_s ^ (w_s >> s_eff);
      for (int k = 1; k < MAX_DEGREE; k++) begin
         a_sh = coeff_rd_ff >> (32'(s_eff) - 1 - k);
         if ((k < 32'(s_eff)) && a_sh[0]) v_rec = v_rec ^ w_ff[k];
      end
      if (32'(cmd.step_idx) <= 32'(s_eff)) begin
         v_new = FB'(m_rd_ff) << (sob_pkg::STEP_W'(FB) - cmd.step_idx);
      end else begin
         v_new = v_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         w_ff[1] <= v_new;
         for (int k = 2; k <= MAX_DEGREE; k++) begin
            w_ff[k] <= w_ff[k-1];
         end
      end
   end

   // coordinate update and output word
   assign lp_cur    = lp_vld_rd_ff ? lp_rd_ff : '0;
   assign emit_last = ((cmd.dim + 1'b1) == dcount);
   always_comb begin
      priority if (cmd.first_pt) begin
         emit_val = '0;
      end else if (cmd.dim == '0) begin
         emit_val = lp_cur ^ (FB'(1) << (sob_pkg::STEP_W'(FB) - cmd.c));
      end else begin
         emit_val = lp_cur ^ w_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         lp_mem[dim_addr] <= emit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_vld_ff <= '0;
      end else if (cmd.clr_lp) begin
         lp_vld_ff <= '0;
      end else if (cmd.emit) begin
         lp_vld_ff[dim_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_err) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         coord_ff   <= emit_val;
         dim_out_ff <= cmd.dim[sob_pkg::DIM_W-1:0];
         last_ff    <= emit_last;
         status_ff  <= sob_pkg::ST_OK;
      end else if (cmd.emit_err) begin
         coord_ff   <= '0;
         dim_out_ff <= '0;
         last_ff    <= 1'b1;
         status_ff  <= cmd.err_code;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_coordinate    = coord_ff;
   assign rsp_dim_out       = dim_out_ff;
   assign rsp_last_of_point = last_ff;
   assign rsp_status        = status_ff;

endmodule

// ----- design/sobol_sequence_generator_top.sv -----
// A load or restart is taken in the idle state. A generate counts the trailing ones
// of k-1 to find C, then per dimension reads the tables, runs C recurrence steps on
// the shared XOR unit for dimensions above 0, and writes back the emitted coordinate.
// Throughput: one request at a time; the next is taken after the last word is queued.
// Reset (synchronous, active high) clears configuration, controller state, point count,
// last-point valid flags and output valid; tables keep their contents.
`timescale 1ns / 1ps
module sobol_sequence_generator_top #(
   parameter int MAX_DIMS   = sob_pkg::DEF_MAX_DIMS,
   parameter int MAX_DEGREE = sob_pkg::DEF_MAX_DEGREE
) (
   input  logic       clock,
   input  logic       reset,
   sob_req_if.sink    req_chan,
   sob_rsp_if.source  rsp_chan,
   sob_csr_if.sink    csr_chan
);

   sob_pkg::cmd_type    cmd;
   sob_pkg::status_type sts;

   sob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sob_dpath #(
      .MAX_DIMS   (MAX_DIMS),
      .MAX_DEGREE (MAX_DEGREE)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_dim_index     (req_chan.dim_index),
      .req_poly_degree   (req_chan.poly_degree),
      .req_poly_coeffs   (req_chan.poly_coeffs),
      .req_m_index       (req_chan.m_index),
      .req_m_value       (req_chan.m_value),
      .csr_valid         (csr_chan.valid),
      .csr_index         (csr_chan.index),
      .csr_data          (csr_chan.data),
      .csr_ready         (csr_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_coordinate    (rsp_chan.coordinate),
      .rsp_dim_out       (rsp_chan.dim_out),
      .rsp_last_of_point (rsp_chan.last_of_point),
      .rsp_status        (rsp_chan.status)
   );

endmodule

// ----- design/sob_checker.sv -----
// Port-level checks on the response channel, bound to the top level.
`timescale 1ns / 1ps
module sob_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [sob_pkg::FRACTION_BITS-1:0]    rsp_coordinate,
   input logic [sob_pkg::DIM_W-1:0]            rsp_dim_out,
   input logic                                 rsp_last_of_point,
   input logic [sob_pkg::STATUS_W-1:0]         rsp_status
);

   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_coordinate)
         && $stable(rsp_dim_out) && $stable(rsp_status))
      else $error("response word changed while stalled");

   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != sob_pkg::ST_OK) |->
         rsp_last_of_point && (rsp_coordinate == '0) && (rsp_dim_out == '0))
      else $error("error word malformed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == sob_pkg::ST_OK) || (rsp_status == sob_pkg::ST_NOT_CFG)
         || (rsp_status == sob_pkg::ST_EXHAUSTED))
      else $error("unknown status code");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sobol_sequence_generator_top sob_checker u_sob_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_coordinate    (rsp_chan.coordinate),
   .rsp_dim_out       (rsp_chan.dim_out),
   .rsp_last_of_point (rsp_chan.last_of_point),
   .rsp_status        (rsp_chan.status)
);

// ----- bench/tb_sobol_sequence_generator_top.sv -----
// Self-checking testbench for the Sobol point generator: table loads, points, errors.
`timescale 1ns / 1ps
module tb_sobol_sequence_generator_top;

   localparam int NDIM = sob_pkg::DEF_MAX_DIMS;
   localparam int NDEG = sob_pkg::DEF_MAX_DEGREE;
   localparam int CYCLE_LIMIT = 5000000;
   localparam int SETTLE = 60;

   typedef struct {
      logic [sob_pkg::OP_W-1:0]     op;
      logic [sob_pkg::DIM_W-1:0]    dim;
      logic [sob_pkg::DEGREE_W-1:0] degree;
      logic [sob_pkg::COEFF_W-1:0]  coeffs;
      logic [sob_pkg::MIDX_W-1:0]   midx;
      logic [sob_pkg::MVAL_W-1:0]   mval;
      bit                           drain;
   } item_type;

   typedef struct {
      logic [sob_pkg::FRACTION_BITS-1:0] coord;
      logic [sob_pkg::DIM_W-1:0]         dim;
      logic                              last;
      logic [sob_pkg::STATUS_W-1:0]      status;
   } word_type;

   logic clock;
   logic reset;

   sob_req_if req_if();
   sob_rsp_if rsp_if();
   sob_csr_if csr_if();

   sobol_sequence_generator_top uut (
      .clock(clock), .reset(reset),
      .req_chan(req_if), .rsp_chan(rsp_if), .csr_chan(csr_if)
   );

   // predictor state
   logic [31:0]                  total_points;
   logic [sob_pkg::NDIMS_W-1:0]  dims_reg;
   logic [31:0]                  pt_count;
   logic [31:0]                  coord_state [NDIM];
   logic [sob_pkg::MVAL_W-1:0]   m_tbl [NDIM][NDEG];
   logic [sob_pkg::DEGREE_W-1:0] deg_tbl [NDIM];
   logic [sob_pkg::COEFF_W-1:0]  coef_tbl [NDIM];

   // stimulus planning: which table entries are written so far
   bit                  plan_deg_ok [NDIM];
   int                  plan_deg [NDIM];
   bit                  plan_m_ok [NDIM][NDEG];
   int                  plan_dims;

   item_type  item_q[$];
   word_type  coord_expect_q[$];
   item_type  cur_item;
   bit     offering;
   int     sender_idle_pct;
   int     recv_idle_pct;
   int     hold_cnt;
   int     errors;
   int     cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int eff_degree(int d);
      if (d == 0) return 1;
      if (d > NDEG) return NDEG;
      return d;
   endfunction

   function automatic logic [31:0] direction_word(int d, int c);
      logic [31:0] v [0:32];
      logic [31:0] x;
      int s;
      s = eff_degree(deg_tbl[d]);
      for (int i = 0; i <= 32; i++) v[i] = '0;
      for (int i = 1; i <= c && i <= s; i++)
         v[i] = 32'(m_tbl[d][i-1]) << (32 - i);
      for (int i = s + 1; i <= c; i++) begin
         x = v[i-s] ^ (v[i-s] >> s);
         for (int k = 1; k + 1 <= s; k++)
            if (coef_tbl[d][s-1-k]) x ^= v[i-k];
         v[i] = x;
      end
      return v[c];
   endfunction

   function automatic void push_status(logic [sob_pkg::STATUS_W-1:0] code);
      word_type w;
      w.coord = '0; w.dim = '0; w.last = 1'b1; w.status = code;
      coord_expect_q = {coord_expect_q, w};
   endfunction

   function automatic void predict_point();
      int dcount, c;
      logic [31:0] k, rem;
      word_type w;
      dcount = (dims_reg > NDIM) ? NDIM : dims_reg;
      if (total_points == 0 || dcount == 0) begin
         push_status(sob_pkg::ST_NOT_CFG);
         return;
      end
      if (pt_count >= total_points) begin
         push_status(sob_pkg::ST_EXHAUSTED);
         return;
      end
      k = pt_count;
      pt_count = k + 1;
      if (k == 0) begin
         for (int j = 0; j < NDIM; j++) coord_state[j] = '0;
      end else begin
         rem = k - 1;
         c = 1;
         while (rem[0] && c < sob_pkg::FRACTION_BITS) begin
            rem = rem >> 1;
            c++;
         end
         coord_state[0] ^= 32'h1 << (sob_pkg::FRACTION_BITS - c);
         for (int j = 1; j < dcount; j++) coord_state[j] ^= direction_word(j, c);
      end
      for (int j = 0; j < dcount; j++) begin
         w.coord = coord_state[j];
         w.dim = sob_pkg::DIM_W'(j);
         w.last = (j + 1 == dcount);
         w.status = sob_pkg::ST_OK;
         coord_expect_q = {coord_expect_q, w};
      end
   endfunction

   function automatic void apply_item(item_type it);
      unique case (it.op)
         sob_pkg::OP_LOAD_POLY: begin
            deg_tbl[it.dim] = it.degree;
            coef_tbl[it.dim] = it.coeffs;
         end
         sob_pkg::OP_LOAD_M:
            if (it.midx >= 1 && it.midx <= NDEG) m_tbl[it.dim][it.midx-1] = it.mval;
         sob_pkg::OP_RESTART: pt_count = '0;
         sob_pkg::OP_GENERATE: predict_point();
         default: ;
      endcase
   endfunction

   // ---- stimulus building ----
   function automatic item_type filler();
      item_type it;
      it.op = sob_pkg::OP_GENERATE;
      it.dim = sob_pkg::DIM_W'($urandom);
      it.degree = sob_pkg::DEGREE_W'($urandom);
      it.coeffs = sob_pkg::COEFF_W'($urandom);
      it.midx = sob_pkg::MIDX_W'($urandom);
      it.mval = sob_pkg::MVAL_W'($urandom);
      it.drain = 1'b0;
      return it;
   endfunction

   function automatic void add_poly(int d, int deg, int coef);
      item_type it;
      it = filler();
      it.op = sob_pkg::OP_LOAD_POLY; it.dim = sob_pkg::DIM_W'(d);
      it.degree = sob_pkg::DEGREE_W'(deg); it.coeffs = sob_pkg::COEFF_W'(coef);
      plan_deg_ok[d] = 1'b1;
      plan_deg[d] = deg;
      item_q = {item_q, it};
   endfunction

   function automatic void add_m(int d, int idx, int val);
      item_type it;
      it = filler();
      it.op = sob_pkg::OP_LOAD_M; it.dim = sob_pkg::DIM_W'(d);
      it.midx = sob_pkg::MIDX_W'(idx); it.mval = sob_pkg::MVAL_W'(val);
      if (idx >= 1 && idx <= NDEG) plan_m_ok[d][idx-1] = 1'b1;
      item_q = {item_q, it};
   endfunction

   function automatic void add_op(logic [sob_pkg::OP_W-1:0] op, bit drain);
      item_type it;
      it = filler();
      it.op = op; it.drain = drain;
      item_q = {item_q, it};
   endfunction

   function automatic int odd_m(int idx);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
      return $urandom_range(0, (1 << (idx - 1)) - 1) * 2 + 1;
   endfunction

   // load whatever the next point will read in dimensions 1..d-1
   function automatic void fill_tables(int d);
      int s;
      for (int j = 1; j < d && j < NDIM; j++) begin
         if (!plan_deg_ok[j]) add_poly(j, $urandom_range(1, 4), $urandom_range(0, 32767));
         s = eff_degree(plan_deg[j]);
         for (int i = 1; i <= s; i++)
            if (!plan_m_ok[j][i-1]) add_m(j, i, odd_m(i));
      end
   endfunction

   function automatic void add_generate(bit drain);
      fill_tables(plan_dims);
      add_op(sob_pkg::OP_GENERATE, drain);
   endfunction

   function automatic void add_random_item();
      int r, dsel, deg;
      r = $urandom_range(0, 99);
      dsel = $urandom_range(0, 9) == 0 ? $urandom_range(0, 63)
                                       : $urandom_range(0, (plan_dims > 1) ? plan_dims - 1 : 1);
      if (r < 55) add_generate($urandom_range(0, 29) == 0);
      else if (r < 62) add_op(sob_pkg::OP_RESTART, 1'b0);
      else if (r < 75) begin
         deg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
         add_poly(dsel, deg, $urandom_range(0, 32767));
      end else if (r < 92) begin
         deg = $urandom_range(1, NDEG);
         add_m(dsel, deg, odd_m(deg));
      end else
         add_m(dsel, ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(NDEG + 1, 31),
               $urandom_range(0, 65535));
   endfunction

   // ---- request driver ----
   always @(posedge clock) begin
      if (!reset && offering && req_if.valid && req_if.ready) begin
         apply_item(cur_item);
         offering = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!offering) begin
         if (item_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
             !(item_q[0].drain && coord_expect_q.size() != 0)) begin
            cur_item = item_q.pop_front();
            offering = 1'b1;
            req_if.valid <= 1'b1;
            req_if.operation <= cur_item.op;
            req_if.dim_index <= cur_item.dim;
            req_if.poly_degree <= cur_item.degree;
            req_if.poly_coeffs <= cur_item.coeffs;
            req_if.m_index <= cur_item.midx;
            req_if.m_value <= cur_item.mval;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---- response monitor ----
   always @(posedge clock) begin
      word_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.coord = rsp_if.coordinate;
         got.dim = rsp_if.dim_out;
         got.last = rsp_if.last_of_point;
         got.status = rsp_if.status;
         if (coord_expect_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: coord=%h dim=%0d last=%b status=%0d",
                        got.coord, got.dim, got.last, got.status);
         end else begin
            want = coord_expect_q.pop_front();
            if (got.coord !== want.coord || got.dim !== want.dim ||
                got.last !== want.last || got.status !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch: exp coord=%h dim=%0d last=%b status=%0d",
                            " / got coord=%h dim=%0d last=%b status=%0d"},
                           want.coord, want.dim, want.last, want.status,
                           got.coord, got.dim, got.last, got.status);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (item_q.size() != 0 || offering || coord_expect_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [sob_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock);
      while (!csr_if.ready);
      if (idx == sob_pkg::REG_NUM_POINTS) total_points = val;
      else dims_reg = val[sob_pkg::NDIMS_W-1:0];
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic configure(logic [31:0] n, int d);
      write_reg(sob_pkg::REG_NUM_POINTS, n);
      write_reg(sob_pkg::REG_NUM_DIMS, d);
      plan_dims = (d > NDIM) ? NDIM : d;
   endtask

   task automatic random_phase(int sidle, int ridle, int count);
      sender_idle_pct = sidle;
      recv_idle_pct = ridle;
      wait_idle();
      configure(($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(1, 40),
                $urandom_range(1, 8));
      for (int i = 0; i < count; i++) add_random_item();
      wait_idle();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.operation = sob_pkg::OP_LOAD_POLY;
      req_if.dim_index = '0;
      req_if.poly_degree = '0;
      req_if.poly_coeffs = '0;
      req_if.m_index = '0;
      req_if.m_value = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = sob_pkg::REG_NUM_POINTS;
      csr_if.data = '0;
      total_points = '0;
      dims_reg = '0;
      pt_count = '0;
      plan_dims = 0;
      offering = 1'b0;
      hold_cnt = 0;
      errors = 0;
      cycles = 0;
      sender_idle_pct = 9;
      recv_idle_pct = 74;
      for (int j = 0; j < NDIM; j++) begin
         coord_state[j] = '0;
         deg_tbl[j] = '0;
         coef_tbl[j] = '0;
         plan_deg_ok[j] = 1'b0;
         plan_deg[j] = 0;
         for (int i = 0; i < NDEG; i++) begin
            m_tbl[j][i] = '0;
            plan_m_ok[j][i] = 1'b0;
         end
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // not configured: registers at reset, then D still zero
      add_op(sob_pkg::OP_GENERATE, 1'b0);
      wait_idle();
      configure(32'd4, 0);
      add_op(sob_pkg::OP_GENERATE, 1'b0);
      wait_idle();

      // degree 0 acts as 1, degree above the max acts as the max; odd-rule breakers
      configure(32'd4, 3);
      add_poly(1, 0, 0);
      add_m(1, 1, 1);
      add_poly(2, 31, 32'h7FFF);
      for (int i = 1; i <= NDEG; i++) add_m(2, i, (i == 3) ? 16'hFFFF : ((i == 5) ? 4 : odd_m(i)));
      add_m(2, 0, 16'h1234);
      add_m(2, 31, 16'hFFFF);
      for (int i = 0; i < 6; i++) add_generate(1'b0);
      add_op(sob_pkg::OP_RESTART, 1'b1);
      add_generate(1'b0);
      add_generate(1'b0);
      wait_idle();
      // lowering N below the count exhausts the sequence
      configure(32'd1, 3);
      add_generate(1'b0);
      wait_idle();

      // every dimension, widest N, with a long receiver stall
      configure(32'hFFFF_FFFF, 127);
      add_poly(63, 16, 32'h7FFF);
      add_m(63, NDEG, 16'hFFFF);
      fill_tables(NDIM);
      add_op(sob_pkg::OP_RESTART, 1'b0);
      wait_idle();
      hold_cnt = 600;
      for (int i = 0; i < 4; i++) add_generate(1'b0);
      add_generate(1'b1);
      wait_idle();

      random_phase(9, 74, 10);
      random_phase(9, 74, 10);
      random_phase(74, 9, 10);
      random_phase(74, 9, 10);
      random_phase(0, 0, 10);
      random_phase(0, 0, 10);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
